FILE: rtl/core/handheld_io_timer_irq_joypad_assert.svh
// Assertion macros for the RTL of the handheld I/O register block.
`ifndef HANDHELD_IO_TIMER_IRQ_JOYPAD_ASSERT_SVH
`define HANDHELD_IO_TIMER_IRQ_JOYPAD_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define HITJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define HITJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HITJ_ASSERT_NOW(label, ante, cons, msg)
`define HITJ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/hitj_pkg.sv
// Types, register offsets and a helper function of the handheld I/O register block.
package hitj_pkg;

	localparam int IO_BYTES_DEF = 256;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	localparam logic [7:0] ADDR_P1       = 8'h00;
	localparam logic [7:0] ADDR_DIV      = 8'h04;
	localparam logic [7:0] ADDR_TIMA     = 8'h05;
	localparam logic [7:0] ADDR_TMA      = 8'h06;
	localparam logic [7:0] ADDR_TAC      = 8'h07;
	localparam logic [7:0] ADDR_IF       = 8'h0F;
	localparam logic [7:0] ADDR_AUDIO_LO = 8'h10;
	localparam logic [7:0] ADDR_AUDIO_HI = 8'h3F;
	localparam logic [7:0] ADDR_VIDEO_LO = 8'h40;
	localparam logic [7:0] ADDR_VIDEO_HI = 8'h4B;
	localparam logic [7:0] ADDR_BOOT     = 8'h50;
	localparam logic [7:0] ADDR_IE       = 8'hFF;

	localparam logic [7:0] JOYPAD_IDLE   = 8'hCF;
	localparam int         TIMER_IRQ_BIT = 2;
	localparam int         TAC_ENABLE    = 2;
	localparam int         P1_SEL_ACTION = 5;
	localparam int         P1_SEL_DIR    = 4;

	typedef struct packed {
		op_t        operation;
		logic [7:0] address;
		logic [7:0] write_data;
		logic [7:0] cycles;
		logic [2:0] irq_index;
		logic [7:0] buttons;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       external_range;
		logic       irq_pending;
		logic [2:0] irq_number;
		logic       bootrom_enabled;
	} rsp_word_t;

	// Timer period for the TAC clock select field, compared against the timer prescaler sum.
	function automatic logic [10:0] timer_period(logic [1:0] sel);
		logic [10:0] p;
		case (sel)
			2'd0: p = 11'd1024;
			2'd1: p = 11'd16;
			2'd2: p = 11'd64;
			2'd3: p = 11'd256;
			default: p = 11'd1024;
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/core/hitj_ifs.sv
// Valid/ready channel interfaces for command and response words.
interface hitj_cmd_if;
	import hitj_pkg::*;
	logic      valid;
	logic      ready;
	cmd_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hitj_rsp_if;
	import hitj_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/handheld_io_timer_irq_joypad.sv
// I/O register page of a handheld console: joypad, divider, timer and interrupt flags.
//
// The block takes one command word per clock cycle while the output is not stalled (read,
// write, tick of an elapsed count, or interrupt acknowledge) and returns exactly one
// response word for each, in order. Each response passes through the registered read port
// of the byte store and then the response register. A command is accepted while a response
// still waits at the output, as long as the input stage can move on.
// Timer, divider, joypad select, interrupt flag and boot-ROM registers live in flip-flops;
// all other offsets below IO_BYTES live in a byte memory with one valid bit per entry, so
// an entry never written reads as zero and no clearing pass is needed after reset.
// Offsets in the audio (0x10..0x3F) and video (0x40..0x4B) ranges are flagged as external,
// read as zero and ignore writes. IE sits at offset 0xFF, apart from the store.
module handheld_io_timer_irq_joypad #(
	parameter int IO_BYTES = hitj_pkg::IO_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	hitj_cmd_if.sink    cmd,
	hitj_rsp_if.source  rsp
);
	import hitj_pkg::*;

	localparam int AW = $clog2(IO_BYTES);

	// Everything the response needs, captured when a command is accepted.
	typedef struct packed {
		logic       rd_from_mem;
		logic [7:0] rd_value;
		logic       external_range;
		logic       irq_pending;
		logic [2:0] irq_number;
		logic       bootrom_enabled;
	} s1_word_t;

	// Architectural registers held in flip-flops.
	logic [7:0]  p1_q, div_q, tima_q, tma_q, tac_q, if_q, boot_q, ie_q;
	logic [8:0]  div_pre_q;
	logic [10:0] tmr_pre_q;
	logic [7:0]  p1_d, div_d, tima_d, tma_d, tac_d, if_d, boot_d, ie_d;
	logic [8:0]  div_pre_d, div_sum;
	logic [10:0] tmr_pre_d, tmr_sum;

	// Byte store for the remaining offsets.
	logic [7:0]          mem [IO_BYTES];
	logic [IO_BYTES-1:0] mem_valid_q;
	logic [AW-1:0]       mem_idx;
	logic                mem_we;
	logic [7:0]          mem_rd_s1;
	logic                mem_valid_s1;

	// Pipeline control.
	logic      s1_valid_q, out_valid_q, s1_adv, accept;
	s1_word_t  s1_d, s1_q;
	rsp_word_t out_q;

	cmd_word_t  c;
	logic       in_store, ext, timer_step, timer_wrap, div_clear;
	logic [7:0] pend, joy;
	logic [2:0] num;

	assign c       = cmd.data;
	assign accept  = cmd.valid && cmd.ready;
	assign mem_idx = c.address[AW-1:0];

	// The input stage drains into the response register when that register is empty or
	// is being taken in this cycle.
	assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign cmd.ready = !s1_valid_q || s1_adv;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		in_store = ({1'b0, c.address} < 9'(IO_BYTES));
		ext = c.address inside {[ADDR_AUDIO_LO:ADDR_AUDIO_HI], [ADDR_VIDEO_LO:ADDR_VIDEO_HI]};

		p1_d      = p1_q;
		div_d     = div_q;
		tima_d    = tima_q;
		tma_d     = tma_q;
		tac_d     = tac_q;
		if_d      = if_q;
		boot_d    = boot_q;
		ie_d      = ie_q;
		div_pre_d = div_pre_q;
		tmr_pre_d = tmr_pre_q;
		mem_we    = 1'b0;

		// Both prescaler sums are formed at their register width; the timer sum meets the period compare.
		div_sum    = div_pre_q + {1'b0, c.cycles};
		tmr_sum    = tmr_pre_q + {3'b000, c.cycles};
		timer_step = tac_q[TAC_ENABLE] && (tmr_sum >= timer_period(tac_q[1:0]));
		timer_wrap = 1'b0;
		div_clear  = 1'b0;

		case (c.operation)
			OP_READ: begin
			end
			OP_WRITE: begin
				if (!ext) begin
					case (c.address)
						ADDR_IE:   ie_d = c.write_data;
						ADDR_P1:   p1_d = c.write_data;
						ADDR_DIV: begin
							div_d     = 8'd0;
							div_clear = accept;
						end
						ADDR_TIMA: tima_d = c.write_data;
						ADDR_TMA:  tma_d = c.write_data;
						ADDR_TAC:  tac_d = c.write_data;
						ADDR_IF:   if_d = c.write_data;
						ADDR_BOOT: boot_d = c.write_data;
						default:   mem_we = in_store;
					endcase
				end
			end
			OP_TICK: begin
				// At most one divider step per tick; the excess count is dropped.
				if (div_sum[8]) begin
					div_d     = div_q + 8'd1;
					div_pre_d = 9'd0;
				end else begin
					div_pre_d = div_sum;
				end
				if (tac_q[TAC_ENABLE]) begin
					if (timer_step) begin
						if (tima_q == 8'hFF) begin
							tima_d              = tma_q;
							if_d[TIMER_IRQ_BIT] = 1'b1;
							timer_wrap          = accept;
						end else begin
							tima_d = tima_q + 8'd1;
						end
						tmr_pre_d = 11'd0;
					end else begin
						tmr_pre_d = tmr_sum;
					end
				end
			end
			OP_ACK: begin
				if_d[c.irq_index] = 1'b0;
			end
			default: begin
			end
		endcase

		// Lowest interrupt that is both flagged and enabled after this command.
		pend = if_d & ie_d;
		num  = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (pend[i]) num = 3'(i);
		end

		// Joypad: a cleared select bit lets the pressed keys of its group pull bits low.
		joy = JOYPAD_IDLE;
		if (!p1_q[P1_SEL_ACTION]) joy = joy & ~{4'b0000, c.buttons[3:0]};
		if (!p1_q[P1_SEL_DIR])    joy = joy & ~{4'b0000, c.buttons[7:4]};

		s1_d.rd_from_mem     = 1'b0;
		s1_d.rd_value        = 8'd0;
		s1_d.external_range  = ext && (c.operation == OP_READ || c.operation == OP_WRITE);
		s1_d.irq_pending     = |pend;
		s1_d.irq_number      = num;
		s1_d.bootrom_enabled = (boot_d == 8'd0);

		if (c.operation == OP_READ) begin
			if (c.address == ADDR_IE) begin
				s1_d.rd_value = ie_q;
			end else if (c.address == ADDR_P1) begin
				s1_d.rd_value = joy;
			end else if (!ext) begin
				case (c.address)
					ADDR_DIV:  s1_d.rd_value = div_q;
					ADDR_TIMA: s1_d.rd_value = tima_q;
					ADDR_TMA:  s1_d.rd_value = tma_q;
					ADDR_TAC:  s1_d.rd_value = tac_q;
					ADDR_IF:   s1_d.rd_value = if_q;
					ADDR_BOOT: s1_d.rd_value = boot_q;
					default:   s1_d.rd_from_mem = in_store;
				endcase
			end
		end
	end

	// Architectural state changes at the edge that accepts the command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q        <= '0;
			div_q       <= '0;
			tima_q      <= '0;
			tma_q       <= '0;
			tac_q       <= '0;
			if_q        <= '0;
			boot_q      <= '0;
			ie_q        <= '0;
			div_pre_q   <= '0;
			tmr_pre_q   <= '0;
			mem_valid_q <= '0;
		end else if (accept) begin
			p1_q      <= p1_d;
			div_q     <= div_d;
			tima_q    <= tima_d;
			tma_q     <= tma_d;
			tac_q     <= tac_d;
			if_q      <= if_d;
			boot_q    <= boot_d;
			ie_q      <= ie_d;
			div_pre_q <= div_pre_d;
			tmr_pre_q <= tmr_pre_d;
			if (mem_we) mem_valid_q[mem_idx] <= 1'b1;
		end
	end

	// Byte store: at most one write and one registered read per accepted command. A command
	// either reads or writes, so the read sees every earlier write.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (mem_we) mem[mem_idx] <= c.write_data;
			mem_rd_s1    <= mem[mem_idx];
			mem_valid_s1 <= mem_valid_q[mem_idx];
			s1_q         <= s1_d;
		end
	end

	// Response register. An entry never written reads as zero through its valid bit.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.read_data       <= s1_q.rd_from_mem ? (mem_valid_s1 ? mem_rd_s1 : 8'd0)
			                                          : s1_q.rd_value;
			out_q.external_range  <= s1_q.external_range;
			out_q.irq_pending     <= s1_q.irq_pending;
			out_q.irq_number      <= s1_q.irq_number;
			out_q.bootrom_enabled <= s1_q.bootrom_enabled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)      s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			if (s1_adv)         out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	`include "handheld_io_timer_irq_joypad_assert.svh"

	// A TIMA overflow reloads from TMA and raises the timer interrupt flag.
	`HITJ_ASSERT_NEXT(a_timer_reload, timer_wrap, if_q[TIMER_IRQ_BIT] && (tima_q == $past(tma_q)), "TIMA overflow did not reload or flag")
	// Any write to DIV leaves it at zero.
	`HITJ_ASSERT_NEXT(a_div_clear, div_clear, div_q == 8'd0, "DIV write did not clear DIV")
	// With both stages full and the output stalled, no command may enter.
	`HITJ_ASSERT_NOW(a_full_stall, s1_valid_q && out_valid_q && !rsp.ready, !cmd.ready, "command accepted into a full pipeline")

endmodule
